### rtl/core/dimt_pkg.sv
// package: sizes, codes and shared types of the disjoint interval merge table
`timescale 1ns / 1ps
`default_nettype none
package dimt_pkg;

	// table depth and value width
	localparam int MAX_INTERVALS = 16;
	localparam int VALUE_BITS    = 16;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [VALUE_BITS:0]   val_ext_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [15:0]           field_t;
	typedef logic [4:0]            cnt_field_t;

	// request opcodes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_DUMP = 1'b1;

	// result kinds
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_DUMP = 1'b1;

	typedef struct packed {
		logic   opcode;
		field_t value;
	} req_t;

	typedef struct packed {
		logic       kind;
		field_t     lower_bound;
		field_t     upper_bound_value;
		cnt_field_t interval_count;
		logic       overflow;
		logic       empty_res;
		logic       last;
	} res_t;

	// one stored interval
	typedef struct packed {
		val_t lo;
		val_t hi;
	} ent_t;

	// update broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_JOIN_L,
		CELL_JOIN_R,
		CELL_MERGE,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		val_t     v;
	} cell_ctl_t;

	// occupancy and ordering seen from the neighbors
	typedef struct packed {
		logic valid;
		logic valid_next;
		logic le_prev;
		logic le_next;
	} cell_nbr_t;

	// what a cell reports about the incoming value
	typedef struct packed {
		logic left;
		logic right;
		logic cov;
		logic jl;
		logic jr;
	} cell_flags_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} dimt_state_t;

endpackage
`default_nettype wire

### rtl/core/dimt_cell.sv
// one table cell: holds an interval, compares it to the value, shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module dimt_cell (
	input  wire logic                  clk,
	input  wire dimt_pkg::cell_ctl_t   ctl,
	input  wire dimt_pkg::cell_nbr_t   nbr,
	input  wire dimt_pkg::ent_t        prev_ent,
	input  wire dimt_pkg::ent_t        next_ent,
	input  wire dimt_pkg::ent_t        head_ent,
	output dimt_pkg::ent_t             ent,
	output logic                       le,
	output dimt_pkg::cell_flags_t      flags
);

	dimt_pkg::ent_t ent_q;
	logic           is_left;
	logic           is_right;

	assign ent = ent_q;

	// start at or below the value: this cell lies left of the insertion point
	assign le       = nbr.valid && (ent_q.lo <= ctl.v);
	assign is_left  = le && !nbr.le_next;
	assign is_right = nbr.valid && !le && nbr.le_prev;

	// adjacency tested one bit wider so the top value never wraps to zero
	always_comb begin
		flags.left  = is_left;
		flags.right = is_right;
		flags.cov   = is_left && (ent_q.hi >= ctl.v);
		flags.jl    = is_left && ((dimt_pkg::val_ext_t'(ent_q.hi) + dimt_pkg::val_ext_t'(1))
			== dimt_pkg::val_ext_t'(ctl.v));
		flags.jr    = is_right && ((dimt_pkg::val_ext_t'(ctl.v) + dimt_pkg::val_ext_t'(1))
			== dimt_pkg::val_ext_t'(ent_q.lo));
	end

	// interval update
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			dimt_pkg::CELL_HOLD: begin
			end
			dimt_pkg::CELL_JOIN_L: begin
				if (is_left) ent_q.hi <= ctl.v;
			end
			dimt_pkg::CELL_JOIN_R: begin
				if (is_right) ent_q.lo <= ctl.v;
			end
			dimt_pkg::CELL_MERGE: begin
				if (is_left) ent_q.hi <= next_ent.hi;
				else if (!le) ent_q <= next_ent;
			end
			dimt_pkg::CELL_INSERT: begin
				if (!le) begin
					if (nbr.le_prev) begin
						ent_q.lo <= ctl.v;
						ent_q.hi <= ctl.v;
					end else begin
						ent_q <= prev_ent;
					end
				end
			end
			dimt_pkg::CELL_ROTATE: begin
				if (nbr.valid && !nbr.valid_next) ent_q <= head_ent;
				else ent_q <= next_ent;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/disjoint_interval_merge_table.sv
// top level: cell chain, add decision, dump sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
// Sorted table of disjoint, non-adjacent intervals held in a row of cells. An add
// is resolved in the cycle it is accepted (all cells compare the value at once) and
// its single result appears on the result port with result_valid in the next cycle;
// adds may follow each other every cycle and busy stays low. A dump keeps busy high
// while the cell row rotates one place per cycle, so one interval leaves per cycle,
// in ascending order; the first goes through the state register and then the result
// register after the dump transaction is accepted, so it comes later than an add
// result. The table is back in place when the dump ends. A dump of an empty table
// gives its one result the next cycle and never raises busy. Every result is shown
// for exactly one cycle and must be taken then. The table needs no clearing after
// reset: only the count, state, index and result valid registers are cleared.
module disjoint_interval_merge_table (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire dimt_pkg::req_t request,
	output logic                busy,
	output logic                result_valid,
	output dimt_pkg::res_t      result
);

	localparam int N = dimt_pkg::MAX_INTERVALS;

	dimt_pkg::dimt_state_t state_q, state_d;
	dimt_pkg::cnt_t        count_q, count_d;
	dimt_pkg::cnt_t        idx_q, idx_d;
	dimt_pkg::res_t        result_q, result_d;
	logic                  result_valid_q, result_valid_d;

	dimt_pkg::cell_ctl_t   ctl;
	dimt_pkg::cell_op_t    op;
	dimt_pkg::val_t        v;

	dimt_pkg::ent_t        ent [N];
	logic                  le [N];
	dimt_pkg::cell_flags_t flags [N];
	logic                  valid [N];

	logic                  any_cov, any_jl, any_jr;
	dimt_pkg::val_t        left_lo, left_hi, right_hi;

	assign v   = dimt_pkg::val_t'(request.value);
	assign ctl = '{op: op, v: v};

	// cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		dimt_pkg::cell_nbr_t nbr;
		dimt_pkg::ent_t      prev_ent, next_ent;

		assign valid[i] = count_q > dimt_pkg::cnt_t'(i);

		if (i == 0) begin : g_first
			assign nbr.le_prev = 1'b1;
			assign prev_ent    = '0;
		end else begin : g_mid
			assign nbr.le_prev = le[i-1];
			assign prev_ent    = ent[i-1];
		end

		if (i == N - 1) begin : g_last
			assign nbr.le_next    = 1'b0;
			assign nbr.valid_next = 1'b0;
			assign next_ent       = '0;
		end else begin : g_inner
			assign nbr.le_next    = le[i+1];
			assign nbr.valid_next = valid[i+1];
			assign next_ent       = ent[i+1];
		end

		assign nbr.valid = valid[i];

		dimt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.nbr      (nbr),
			.prev_ent (prev_ent),
			.next_ent (next_ent),
			.head_ent (ent[0]),
			.ent      (ent[i]),
			.le       (le[i]),
			.flags    (flags[i])
		);
	end

	// gather the neighbor flags and bounds (one cell at most is left, one is right)
	always_comb begin
		any_cov  = 1'b0;
		any_jl   = 1'b0;
		any_jr   = 1'b0;
		left_lo  = '0;
		left_hi  = '0;
		right_hi = '0;
		for (int i = 0; i < N; i++) begin
			any_cov  = any_cov | flags[i].cov;
			any_jl   = any_jl | flags[i].jl;
			any_jr   = any_jr | flags[i].jr;
			left_lo  = left_lo | (flags[i].left ? ent[i].lo : '0);
			left_hi  = left_hi | (flags[i].left ? ent[i].hi : '0);
			right_hi = right_hi | (flags[i].right ? ent[i].hi : '0);
		end
	end

	// state, count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dimt_pkg::ST_IDLE;
			count_q        <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			idx_q          <= idx_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	// next state, cell update and result
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		idx_d          = idx_q;
		op             = dimt_pkg::CELL_HOLD;
		result_valid_d = 1'b0;
		result_d       = '0;
		unique case (state_q)
			dimt_pkg::ST_IDLE: begin
				if (start) begin
					result_valid_d = 1'b1;
					result_d.last  = 1'b1;
					if (request.opcode == dimt_pkg::OP_DUMP) begin
						result_d.kind = dimt_pkg::KIND_DUMP;
						if (count_q == '0) begin
							result_d.empty_res = 1'b1;
						end else begin
							result_valid_d = 1'b0;
							state_d        = dimt_pkg::ST_DUMP;
							idx_d          = '0;
						end
					end else begin
						result_d.kind = dimt_pkg::KIND_ADD;
						priority if (any_cov) begin
							result_d.lower_bound       = dimt_pkg::field_t'(left_lo);
							result_d.upper_bound_value = dimt_pkg::field_t'(left_hi);
						end else if (any_jl && any_jr) begin
							op      = dimt_pkg::CELL_MERGE;
							count_d = count_q - dimt_pkg::cnt_t'(1);
							result_d.lower_bound       = dimt_pkg::field_t'(left_lo);
							result_d.upper_bound_value = dimt_pkg::field_t'(right_hi);
						end else if (any_jl) begin
							op = dimt_pkg::CELL_JOIN_L;
							result_d.lower_bound       = dimt_pkg::field_t'(left_lo);
							result_d.upper_bound_value = dimt_pkg::field_t'(v);
						end else if (any_jr) begin
							op = dimt_pkg::CELL_JOIN_R;
							result_d.lower_bound       = dimt_pkg::field_t'(v);
							result_d.upper_bound_value = dimt_pkg::field_t'(right_hi);
						end else if (count_q == dimt_pkg::cnt_t'(N)) begin
							result_d.overflow = 1'b1;
						end else begin
							op      = dimt_pkg::CELL_INSERT;
							count_d = count_q + dimt_pkg::cnt_t'(1);
							result_d.lower_bound       = dimt_pkg::field_t'(v);
							result_d.upper_bound_value = dimt_pkg::field_t'(v);
						end
					end
					result_d.interval_count = dimt_pkg::cnt_field_t'(count_d);
				end
			end
			dimt_pkg::ST_DUMP: begin
				// head cell leaves, row rotates by one
				op                         = dimt_pkg::CELL_ROTATE;
				result_valid_d             = 1'b1;
				result_d.kind              = dimt_pkg::KIND_DUMP;
				result_d.lower_bound       = dimt_pkg::field_t'(ent[0].lo);
				result_d.upper_bound_value = dimt_pkg::field_t'(ent[0].hi);
				result_d.interval_count    = dimt_pkg::cnt_field_t'(count_q);
				idx_d                      = idx_q + dimt_pkg::cnt_t'(1);
				if (idx_q == count_q - dimt_pkg::cnt_t'(1)) begin
					result_d.last = 1'b1;
					state_d       = dimt_pkg::ST_IDLE;
				end
			end
		endcase
	end

	assign busy         = (state_q == dimt_pkg::ST_DUMP);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dimt_pkg::cnt_t'(N))
		else $error("interval count above table depth");

	a_add_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.opcode == dimt_pkg::OP_ADD) |=>
		(result_valid && result.kind == dimt_pkg::KIND_ADD && result.last))
		else $error("add transaction without its single result");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == dimt_pkg::KIND_DUMP && result.last) |-> !busy)
		else $error("busy still high after last dumped interval");

	a_dump_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> (result_valid && !result.empty_res && !result.overflow))
		else $error("dump cycle without a proper interval result");

endmodule
`default_nettype wire
